@@ rtl/mma_pkg.sv @@
package mma_pkg;

  // Operation codes carried in the input tuser field.
  typedef enum logic [2:0] {
    MODE_TO_MONT   = 3'd0,
    MODE_FROM_MONT = 3'd1,
    MODE_ADD       = 3'd2,
    MODE_SUB       = 3'd3,
    MODE_MUL       = 3'd4,
    MODE_POW       = 3'd5,
    MODE_INV       = 3'd6,
    MODE_EQUAL     = 3'd7
  } mma_mode_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_MODULUS     = 2'd0;
  localparam logic [1:0] REG_MODULUS_INV = 2'd1;
  localparam logic [1:0] REG_R_SQUARED   = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_NEG,
    S_SUB,
    S_ARITH,
    S_DIV,
    S_INV,
    S_MP,
    S_MQ,
    S_MS,
    S_ALO,
    S_AHI,
    S_MMD,
    S_FIN
  } mma_state_t;

  // Which Montgomery product of a multi-product operation is running.
  typedef enum logic [1:0] {
    PH_FIRST,
    PH_SECOND,
    PH_ACC,
    PH_SQ
  } mma_phase_t;

  // Status of a serial unit.
  typedef struct packed {
    logic busy;
    logic done;
  } mma_stat_t;

endpackage

@@ rtl/mma_mul.sv @@
module mma_mul
  import mma_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [63:0]   x,
  input  logic [63:0]   y,
  output mma_stat_t     stat,
  output logic [127:0]  prod
);

  localparam logic [5:0] LAST = 6'd63;

  logic [63:0]  x_r;
  logic [63:0]  y_r;
  logic [127:0] acc_r;
  logic [5:0]   cnt_r;
  logic         busy_r;
  logic         done_r;
  logic [64:0]  add_s;

  // One multiplier bit per cycle, least significant first; the partial
  // sum shifts right so the adder stays 64 bits wide.
  assign add_s = {1'b0, acc_r[127:64]} + (y_r[0] ? {1'b0, x_r} : 65'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= x;
      y_r   <= y;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= {add_s, acc_r[63:1]};
      y_r   <= {1'b0, y_r[63:1]};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign prod      = acc_r;

endmodule

@@ rtl/mma_div.sv @@
module mma_div
  import mma_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [62:0]  dividend,
  input  logic [61:0]  divisor,
  output mma_stat_t    stat,
  output logic [61:0]  rem
);

  localparam logic [5:0] LAST = 6'd62;

  logic [61:0] rem_r;
  logic [62:0] dvd_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [62:0] trial_s;
  logic [63:0] diff_s;

  // Restoring remainder, one dividend bit per cycle from the top.
  assign trial_s = {rem_r, dvd_r[62]};
  assign diff_s  = {1'b0, trial_s} - {2'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvd_r <= dividend;
    end else if (busy_r) begin
      rem_r <= diff_s[63] ? trial_s[61:0] : diff_s[61:0];
      dvd_r <= {dvd_r[61:0], 1'b0};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign rem       = rem_r;

endmodule

@@ rtl/mma_inv.sv @@
module mma_inv
  import mma_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [61:0]  value,
  input  logic [61:0]  modulus,
  output mma_stat_t    stat,
  output logic         ok,
  output logic [61:0]  inv
);

  // Binary extended gcd for an odd modulus. Invariants: x1*value == u and
  // x2*value == v modulo the modulus; v stays odd.
  logic [61:0] u_r;
  logic [61:0] v_r;
  logic [61:0] x1_r;
  logic [61:0] x2_r;
  logic        busy_r;
  logic        done_r;
  logic [62:0] uv_s;
  logic [62:0] vu_s;
  logic [62:0] x12_s;
  logic [62:0] x21_s;
  logic [61:0] x12m_s;
  logic [61:0] x21m_s;
  logic [62:0] half_s;

  assign uv_s   = {1'b0, u_r} - {1'b0, v_r};
  assign vu_s   = {1'b0, v_r} - {1'b0, u_r};
  assign x12_s  = {1'b0, x1_r} - {1'b0, x2_r};
  assign x21_s  = {1'b0, x2_r} - {1'b0, x1_r};
  assign x12m_s = x12_s[62] ? x12_s[61:0] + modulus : x12_s[61:0];
  assign x21m_s = x21_s[62] ? x21_s[61:0] + modulus : x21_s[61:0];
  assign half_s = x1_r[0] ? {1'b0, x1_r} + {1'b0, modulus} : {1'b0, x1_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (u_r == '0)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      u_r  <= value;
      v_r  <= modulus;
      x1_r <= 62'd1;
      x2_r <= '0;
    end else if (busy_r && (u_r != '0)) begin
      if (!u_r[0]) begin
        u_r  <= {1'b0, u_r[61:1]};
        x1_r <= half_s[62:1];
      end else if (!uv_s[62]) begin
        u_r  <= uv_s[61:0];
        x1_r <= x12m_s;
      end else begin
        u_r  <= vu_s[61:0];
        v_r  <= u_r;
        x1_r <= x21m_s;
        x2_r <= x1_r;
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign ok        = (v_r == 62'd1);
  assign inv       = x2_r;

endmodule

@@ rtl/montgomery_modular_alu_core.sv @@
// Montgomery modular arithmetic unit, bit-serial.
// Input channel in_*: one transfer carries an operation code in in_tuser and
// its operands in in_tdata. Result channel out_*: one transfer per input item
// with the residue, the congruence flag and the error flag in out_tdata.
// The cfg_* port writes the modulus, its inverse mod 2^64 and 2^128 mod m;
// write them only while no item is in flight.
// Work: a Montgomery product runs three shift-add multiplications on one
// shared serial multiplier plus a carry add of the low and then the high
// half. Multiply takes one product, from_mont skips the plain product,
// to_mont first takes a serial remainder of a non-negative input unless
// the modulus is zero, and equal, add and sub finish without the multiplier.
// Power takes one product plus one or two per exponent bit up to its
// highest set bit. Inverse takes a serial remainder, binary gcd steps,
// then two products.
// One item is worked on at a time; in_tready is high only while idle.
// A finished result sits in the output register, so the next item can be
// accepted while the receiver stalls; the sequencer waits only if it
// finishes again before that register has been drained.
// Reset clears the sequencer and the output valid, and sets modulus and
// modulus inverse to 1 and r_squared to 0.
module montgomery_modular_alu_core
  import mma_pkg::*;
#(
  parameter int WORD_WIDTH = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  // [63:0] plain_value, [126:64] mont_a, [189:127] mont_b,
  // [252:190] exponent, [255:253] zero
  input  logic [255:0] in_tdata,
  // [2:0] mode
  input  logic [2:0]   in_tuser,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [62:0] result, [63] equal, [64] error, [71:65] zero
  output logic [71:0]  out_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [63:0]  cfg_pwdata,
  output logic [63:0]  cfg_prdata,
  output logic         cfg_pready
);

  // Low word of the reduction factor q is kept to WORD_WIDTH bits.
  localparam logic [63:0] QMASK = {64{1'b1}} >> (64 - WORD_WIDTH);

  // Configuration registers.
  logic [61:0] mod_r;
  logic [63:0] minv_r;
  logic [61:0] r2_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r  <= 62'd1;
      minv_r <= 64'd1;
      r2_r   <= '0;
    end else if (cfg_wr) begin
      case (cfg_paddr[4:3])
        REG_MODULUS:     mod_r  <= cfg_pwdata[61:0];
        REG_MODULUS_INV: minv_r <= cfg_pwdata;
        REG_R_SQUARED:   r2_r   <= cfg_pwdata[61:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[4:3])
      REG_MODULUS:     cfg_prdata = {2'b0, mod_r};
      REG_MODULUS_INV: cfg_prdata = minv_r;
      REG_R_SQUARED:   cfg_prdata = {2'b0, r2_r};
      default:         cfg_prdata = '0;
    endcase
  end

  // Serial units.
  logic         mul_start;
  logic [63:0]  mul_x;
  logic [63:0]  mul_y;
  mma_stat_t    mul_stat;
  logic [127:0] mul_prod;
  logic         div_start;
  logic [62:0]  div_dvd;
  mma_stat_t    div_stat;
  logic [61:0]  div_rem;
  logic         inv_start;
  mma_stat_t    inv_stat;
  logic         inv_ok;
  logic [61:0]  inv_val;

  mma_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .x     (mul_x),
    .y     (mul_y),
    .stat  (mul_stat),
    .prod  (mul_prod)
  );

  mma_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (mod_r),
    .stat     (div_stat),
    .rem      (div_rem)
  );

  mma_inv u_inv (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (inv_start),
    .value   (div_rem),
    .modulus (mod_r),
    .stat    (inv_stat),
    .ok      (inv_ok),
    .inv     (inv_val)
  );

  // Sequencer state and item registers.
  mma_state_t   state_r, state_nxt;
  mma_phase_t   phase_r, phase_nxt;
  mma_mode_t    mode_r, mode_nxt;
  logic [63:0]  pv_r, pv_nxt;
  logic [62:0]  a_r, a_nxt;
  logic [62:0]  b_r, b_nxt;
  logic [62:0]  k_r, k_nxt;
  logic [62:0]  acc_r, acc_nxt;
  logic [62:0]  base_r, base_nxt;
  logic [63:0]  t_r, t_nxt;
  logic [127:0] p_r, p_nxt;
  logic         c_r, c_nxt;
  logic [62:0]  res_r, res_nxt;
  logic         eq_r, eq_nxt;
  logic         err_r, err_nxt;
  logic         out_valid_r;
  logic [71:0]  out_data_r;
  logic         out_load;

  // Shared datapath terms.
  logic [63:0]  m64;
  logic [63:0]  r2_64;
  logic [63:0]  m2;
  logic [63:0]  ninv;
  logic [62:0]  mm;
  logic [62:0]  mm_red;
  logic [63:0]  mm_diff;
  logic [64:0]  lo_sum;
  logic [64:0]  ar_diff;
  logic [62:0]  eq_x;
  logic [62:0]  eq_y;
  logic [61:0]  neg_v;
  logic [62:0]  pw_acc;
  logic [62:0]  pw_base;
  logic [62:0]  pw_k;
  logic         mm_go;
  logic [63:0]  mm_x;
  logic [63:0]  mm_y;

  assign m64     = {2'b0, mod_r};
  assign r2_64   = {2'b0, r2_r};
  assign m2      = {1'b0, mod_r, 1'b0};
  assign ninv    = 64'd0 - minv_r;
  // Reduced product is the sum (P + q*m) shifted down by one word.
  assign mm      = p_r[WORD_WIDTH+62:WORD_WIDTH];
  assign mm_diff = {1'b0, mm} - m64;
  assign mm_red  = mm_diff[63] ? mm : mm_diff[62:0];
  assign lo_sum  = {1'b0, p_r[63:0]} + {1'b0, mul_prod[63:0]};
  assign ar_diff = {1'b0, t_r} - {1'b0, m2};
  assign eq_x    = (a_r >= m64[62:0]) ? a_r - m64[62:0] : a_r;
  assign eq_y    = (b_r >= m64[62:0]) ? b_r - m64[62:0] : b_r;
  assign neg_v   = mod_r - t_r[61:0];

  // Square-and-multiply bookkeeping after an init or square product.
  assign pw_acc  = (phase_r == PH_SQ) ? acc_r : mm;
  assign pw_base = (phase_r == PH_SQ) ? mm : base_r;
  assign pw_k    = (phase_r == PH_SQ) ? {1'b0, k_r[62:1]} : k_r;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    mode_nxt  = mode_r;
    pv_nxt    = pv_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    k_nxt     = k_r;
    acc_nxt   = acc_r;
    base_nxt  = base_r;
    t_nxt     = t_r;
    p_nxt     = p_r;
    c_nxt     = c_r;
    res_nxt   = res_r;
    eq_nxt    = eq_r;
    err_nxt   = err_r;
    mul_start = 1'b0;
    mul_x     = '0;
    mul_y     = '0;
    div_start = 1'b0;
    div_dvd   = '0;
    inv_start = 1'b0;
    out_load  = 1'b0;
    mm_go     = 1'b0;
    mm_x      = '0;
    mm_y      = '0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          mode_nxt  = mma_mode_t'(in_tuser);
          pv_nxt    = in_tdata[63:0];
          a_nxt     = in_tdata[126:64];
          b_nxt     = in_tdata[189:127];
          k_nxt     = in_tdata[252:190];
          res_nxt   = '0;
          eq_nxt    = 1'b0;
          err_nxt   = 1'b0;
          state_nxt = S_START;
        end
      end

      S_START: begin
        case (mode_r)
          MODE_TO_MONT: begin
            if (pv_r[63]) begin
              t_nxt     = 64'd0 - pv_r;
              state_nxt = S_NEG;
            end else if (mod_r == '0) begin
              mm_go = 1'b1;
              mm_y  = r2_64;
            end else begin
              div_start = 1'b1;
              div_dvd   = pv_r[62:0];
              state_nxt = S_DIV;
            end
          end
          MODE_FROM_MONT: begin
            p_nxt     = {64'd0, 1'b0, a_r};
            mul_start = 1'b1;
            mul_x     = {1'b0, a_r};
            mul_y     = ninv;
            state_nxt = S_MQ;
          end
          MODE_ADD: begin
            t_nxt     = {1'b0, a_r} + {1'b0, b_r};
            state_nxt = S_ARITH;
          end
          MODE_SUB: begin
            t_nxt     = {1'b0, a_r} + m2;
            state_nxt = S_SUB;
          end
          MODE_MUL: begin
            mm_go = 1'b1;
            mm_x  = {1'b0, a_r};
            mm_y  = {1'b0, b_r};
          end
          MODE_POW: begin
            base_nxt  = a_r;
            phase_nxt = PH_FIRST;
            mm_go     = 1'b1;
            mm_x      = 64'd1;
            mm_y      = r2_64;
          end
          MODE_INV: begin
            if (!mod_r[0]) begin
              err_nxt   = 1'b1;
              state_nxt = S_FIN;
            end else begin
              div_start = 1'b1;
              div_dvd   = a_r;
              state_nxt = S_DIV;
            end
          end
          MODE_EQUAL: begin
            eq_nxt    = (eq_x == eq_y);
            state_nxt = S_FIN;
          end
          default: state_nxt = S_FIN;
        endcase
      end

      // Negative input: t holds its magnitude.
      S_NEG: begin
        if (t_r > m64) begin
          err_nxt   = 1'b1;
          state_nxt = S_FIN;
        end else begin
          mm_go = 1'b1;
          mm_x  = {2'b0, neg_v};
          mm_y  = r2_64;
        end
      end

      S_SUB: begin
        t_nxt     = t_r - {1'b0, b_r};
        state_nxt = S_ARITH;
      end

      S_ARITH: begin
        res_nxt   = ar_diff[64] ? t_r[62:0] : ar_diff[62:0];
        state_nxt = S_FIN;
      end

      S_DIV: begin
        if (div_stat.done) begin
          if (mode_r == MODE_TO_MONT) begin
            mm_go = 1'b1;
            mm_x  = {2'b0, div_rem};
            mm_y  = r2_64;
          end else if (div_rem != '0) begin
            inv_start = 1'b1;
            state_nxt = S_INV;
          end else if (mod_r == 62'd1) begin
            // Every value is its own inverse's residue class modulo one.
            phase_nxt = PH_FIRST;
            mm_go     = 1'b1;
            mm_y      = r2_64;
          end else begin
            err_nxt   = 1'b1;
            state_nxt = S_FIN;
          end
        end
      end

      S_INV: begin
        if (inv_stat.done) begin
          if (inv_ok) begin
            phase_nxt = PH_FIRST;
            mm_go     = 1'b1;
            mm_x      = {2'b0, inv_val};
            mm_y      = r2_64;
          end else begin
            err_nxt   = 1'b1;
            state_nxt = S_FIN;
          end
        end
      end

      // P = x*y is done; start q = P.lo * (-m^-1).
      S_MP: begin
        if (mul_stat.done) begin
          p_nxt     = mul_prod;
          mul_start = 1'b1;
          mul_x     = mul_prod[63:0];
          mul_y     = ninv;
          state_nxt = S_MQ;
        end
      end

      // q is done; start q*m.
      S_MQ: begin
        if (mul_stat.done) begin
          mul_start = 1'b1;
          mul_x     = mul_prod[63:0] & QMASK;
          mul_y     = m64;
          state_nxt = S_MS;
        end
      end

      S_MS: begin
        if (mul_stat.done) begin
          state_nxt = S_ALO;
        end
      end

      S_ALO: begin
        p_nxt[63:0] = lo_sum[63:0];
        c_nxt       = lo_sum[64];
        state_nxt   = S_AHI;
      end

      S_AHI: begin
        p_nxt[127:64] = p_r[127:64] + mul_prod[127:64] + {63'd0, c_r};
        state_nxt     = S_MMD;
      end

      S_MMD: begin
        case (mode_r)
          MODE_FROM_MONT: begin
            res_nxt   = mm_red;
            state_nxt = S_FIN;
          end
          MODE_POW: begin
            if (phase_r == PH_ACC) begin
              acc_nxt   = mm;
              phase_nxt = PH_SQ;
              mm_go     = 1'b1;
              mm_x      = {1'b0, base_r};
              mm_y      = {1'b0, base_r};
            end else begin
              acc_nxt  = pw_acc;
              base_nxt = pw_base;
              k_nxt    = pw_k;
              if (pw_k == '0) begin
                res_nxt   = pw_acc;
                state_nxt = S_FIN;
              end else if (pw_k[0]) begin
                phase_nxt = PH_ACC;
                mm_go     = 1'b1;
                mm_x      = {1'b0, pw_acc};
                mm_y      = {1'b0, pw_base};
              end else begin
                phase_nxt = PH_SQ;
                mm_go     = 1'b1;
                mm_x      = {1'b0, pw_base};
                mm_y      = {1'b0, pw_base};
              end
            end
          end
          MODE_INV: begin
            if (phase_r == PH_FIRST) begin
              phase_nxt = PH_SECOND;
              mm_go     = 1'b1;
              mm_x      = {1'b0, mm};
              mm_y      = r2_64;
            end else begin
              res_nxt   = mm;
              state_nxt = S_FIN;
            end
          end
          default: begin
            res_nxt   = mm;
            state_nxt = S_FIN;
          end
        endcase
      end

      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // Every Montgomery product started through mm_go begins with the plain product x*y.
    if (mm_go) begin
      mul_start = 1'b1;
      mul_x     = mm_x;
      mul_y     = mm_y;
      state_nxt = S_MP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    phase_r <= phase_nxt;
    mode_r  <= mode_nxt;
    pv_r    <= pv_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    k_r     <= k_nxt;
    acc_r   <= acc_nxt;
    base_r  <= base_nxt;
    t_r     <= t_nxt;
    p_r     <= p_nxt;
    c_r     <= c_nxt;
    res_r   <= res_nxt;
    eq_r    <= eq_nxt;
    err_r   <= err_nxt;
    if (out_load) begin
      out_data_r <= {7'd0, err_r, eq_r, res_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef NO_ASSERTIONS
  // The shared multiplier is never restarted in the middle of a product.
  assert property (@(posedge clk) disable iff (!rst_n)
    mul_start |-> !mul_stat.busy)
    else $error("multiplier restarted while busy");

  // Only one item is in flight at a time.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second item accepted while busy");

  // A flagged result carries a zero residue and no congruence flag.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[64]) |-> (out_tdata[62:0] == '0) && !out_tdata[63])
    else $error("error result is not cleared");

  // A reduced product is only read after both halves of the sum are in.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MMD) |-> ($past(state_r) == S_AHI))
    else $error("reduction read before the carry add finished");
`endif

endmodule
